@@ hdl/dcdt_pkg.sv @@
// Shared types and constants for the dual countdown timer register block.
// Used by dcdt_channel and dual_countdown_timer_regs; depends on nothing else.
package dcdt_pkg;

    localparam int NUM_CHANNELS    = 2;
    localparam int PRESCALE_DIVIDE = 32;
    localparam int PS_W            = $clog2(PRESCALE_DIVIDE);

    localparam int DATA_W = 32;
    localparam int CTRL_W = 8;
    localparam int ADDR_W = 8;
    localparam int IRQ_W  = 2;

    // Control register bits.
    localparam int CTRL_ENABLE   = 0;
    localparam int CTRL_AUTO     = 1;
    localparam int CTRL_INT_EN   = 5;
    localparam int CTRL_PRESCALE = 7;

    // Register offsets within a channel (address bits 3:0).
    localparam logic [3:0] REG_LOAD  = 4'h0;
    localparam logic [3:0] REG_VALUE = 4'h4;
    localparam logic [3:0] REG_CTRL  = 4'h8;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef struct packed {
        logic              tick;
        logic              wr_load;
        logic              wr_ctrl;
        logic [DATA_W-1:0] wdata;
    } chan_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] reload;
        logic [CTRL_W-1:0] ctrl;
        logic [DATA_W-1:0] count;
        logic              irq;
        logic              irq_next;
        logic              pending;
    } chan_stat_t;

endpackage

@@ hdl/dcdt_channel.sv @@
// One timer channel: reload, control and count registers with prescaler.
// Depends on dcdt_pkg for the command and status structs.
module dcdt_channel (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dcdt_pkg::chan_cmd_t   cmd,
    output dcdt_pkg::chan_stat_t  stat
);
    import dcdt_pkg::*;

    logic [DATA_W-1:0] reload_reg, reload_next;
    logic [CTRL_W-1:0] ctrl_reg, ctrl_next;
    logic [DATA_W-1:0] count_reg, count_next;
    logic              run_reg, run_next;
    logic [PS_W-1:0]   ps_reg, ps_next;
    logic              pending_reg, pending_next;
    logic              irq_reg, irq_next;
    logic [DATA_W-1:0] start_value;
    logic              ps_wrap;
    logic              do_count;

    // A zero reload value stands for the full 32-bit range.
    assign start_value = (reload_reg == '0) ? '1 : reload_reg;
    assign ps_wrap     = (ps_reg == PS_W'(PRESCALE_DIVIDE - 1));

    always_comb
    begin
        reload_next  = reload_reg;
        ctrl_next    = ctrl_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        ps_next      = ps_reg;
        pending_next = pending_reg;
        irq_next     = irq_reg;
        do_count     = 1'b0;
        if (cmd.wr_load)
        begin
            reload_next = cmd.wdata;
        end
        else if (cmd.wr_ctrl)
        begin
            ctrl_next = cmd.wdata[CTRL_W-1:0];
            ps_next   = '0;
            if (cmd.wdata[CTRL_ENABLE])
            begin
                count_next = start_value;
                run_next   = 1'b1;
            end
            else
            begin
                run_next = 1'b0;
            end
        end
        else if (cmd.tick && run_reg)
        begin
            if (ctrl_reg[CTRL_PRESCALE])
            begin
                ps_next  = ps_wrap ? '0 : ps_reg + PS_W'(1);
                do_count = ps_wrap;
            end
            else
            begin
                do_count = 1'b1;
            end
        end

        if (do_count)
        begin
            if (count_reg > DATA_W'(1))
            begin
                count_next = count_reg - DATA_W'(1);
            end
            else
            begin
                pending_next = 1'b1;
                if (ctrl_reg[CTRL_INT_EN])
                begin
                    irq_next = 1'b1;
                end
                if (ctrl_reg[CTRL_AUTO])
                begin
                    count_next = start_value;
                end
                else
                begin
                    count_next = '0;
                    run_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg  <= '0;
            ctrl_reg    <= '0;
            count_reg   <= '0;
            run_reg     <= 1'b0;
            ps_reg      <= '0;
            pending_reg <= 1'b0;
            irq_reg     <= 1'b0;
        end
        else
        begin
            reload_reg  <= reload_next;
            ctrl_reg    <= ctrl_next;
            count_reg   <= count_next;
            run_reg     <= run_next;
            ps_reg      <= ps_next;
            pending_reg <= pending_next;
            irq_reg     <= irq_next;
        end
    end

    assign stat.reload   = reload_reg;
    assign stat.ctrl     = ctrl_reg;
    assign stat.count    = count_reg;
    assign stat.irq      = irq_reg;
    assign stat.irq_next = irq_next;
    assign stat.pending  = pending_reg;

endmodule

@@ hdl/dual_countdown_timer_regs.sv @@
// Top level of the dual countdown timer: request decode, read mux and output buffer.
// Depends on dcdt_pkg and dcdt_channel.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------
//  in      | in_valid / in_stall | req_type, address, write_data
//  out     | out_valid/out_stall | read_data, irq_lines
//
// Each item is decoded and applied to the channel registers in the cycle it is
// accepted; its result is registered in the output register, or in the skid slot
// when that is full. One item per cycle is sustained while out_stall stays low.
// A two-entry output buffer (output register plus skid slot) lets the block take
// a new item while a result waits; in_stall rises only when both are full.
// Reset clears all timer state and empties the buffer.
module dual_countdown_timer_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [dcdt_pkg::ADDR_W-1:0]   address,
    input  logic [dcdt_pkg::DATA_W-1:0]   write_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dcdt_pkg::DATA_W-1:0]   read_data,
    output logic [dcdt_pkg::IRQ_W-1:0]    irq_lines
);
    import dcdt_pkg::*;

    chan_cmd_t   cmd  [NUM_CHANNELS];
    chan_stat_t  stat [NUM_CHANNELS];

    logic              push;
    logic              pop;
    logic [3:0]        chan_sel;
    logic [3:0]        reg_sel;
    logic [DATA_W-1:0] rd_value;
    logic [IRQ_W-1:0]  irq_vec;

    logic              head_valid_reg;
    logic [DATA_W-1:0] head_data_reg;
    logic [IRQ_W-1:0]  head_irq_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic [IRQ_W-1:0]  skid_irq_reg;

    assign push     = in_valid && !in_stall;
    assign pop      = head_valid_reg && !out_stall;
    assign chan_sel = address[7:4];
    assign reg_sel  = address[3:0];

    genvar g;
    generate
        for (g = 0; g < NUM_CHANNELS; g++)
        begin : g_chan
            always_comb
            begin
                cmd[g].tick    = push && (req_type == REQ_TICK);
                cmd[g].wr_load = push && (req_type == REQ_WRITE)
                                 && (chan_sel == 4'(g)) && (reg_sel == REG_LOAD);
                cmd[g].wr_ctrl = push && (req_type == REQ_WRITE)
                                 && (chan_sel == 4'(g)) && (reg_sel == REG_CTRL);
                cmd[g].wdata   = write_data;
            end

            dcdt_channel u_chan (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd[g]),
                .stat  (stat[g])
            );
        end

        // Only the first two channels have interrupt lines.
        for (g = 0; g < IRQ_W; g++)
        begin : g_irq
            if (g < NUM_CHANNELS)
            begin : g_on
                assign irq_vec[g] = stat[g].irq_next;
            end
            else
            begin : g_off
                assign irq_vec[g] = 1'b0;
            end
        end
    endgenerate

    // Out-of-range channels and unknown offsets match no arm and read zero.
    always_comb
    begin
        rd_value = '0;
        if (req_type == REQ_READ)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                if (chan_sel == 4'(c))
                begin
                    unique case (reg_sel)
                        REG_LOAD:  rd_value = stat[c].reload;
                        REG_VALUE: rd_value = stat[c].count;
                        REG_CTRL:  rd_value = DATA_W'(stat[c].ctrl);
                        default:   rd_value = '0;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    head_valid_reg <= push;
                end
            end
            else if (push)
            begin
                if (head_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    head_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_data_reg <= skid_data_reg;
                head_irq_reg  <= skid_irq_reg;
            end
            else if (push)
            begin
                head_data_reg <= rd_value;
                head_irq_reg  <= irq_vec;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_data_reg <= rd_value;
                skid_irq_reg  <= irq_vec;
            end
            else
            begin
                head_data_reg <= rd_value;
                head_irq_reg  <= irq_vec;
            end
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign read_data = head_data_reg;
    assign irq_lines = head_irq_reg;

    // The skid slot is only ever filled behind a full output register.
    a_skid_behind_head : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid slot holds an item while the output register is empty");

    generate
        for (g = 0; g < NUM_CHANNELS; g++)
        begin : g_chk
            // An interrupt can only have been raised by an expiry.
            a_irq_implies_pending : assert property (@(posedge clk) disable iff (!rst_n)
                stat[g].irq |-> stat[g].pending)
                else $error("interrupt line high without a pending expiry");

            // Interrupt lines are cleared by reset alone.
            a_irq_sticky : assert property (@(posedge clk) disable iff (!rst_n)
                stat[g].irq |=> stat[g].irq)
                else $error("interrupt line dropped without reset");
        end
    endgenerate

endmodule

@@ tb/tb_dual_countdown_timer_regs.sv @@
// Self-checking testbench for the dual countdown timer register block.
// Depends on dcdt_pkg and dual_countdown_timer_regs; reads no files.
`timescale 1ns / 1ps

module tb_dual_countdown_timer_regs;
    import dcdt_pkg::*;

    localparam int NUM_DIRECTED  = 26;
    localparam int RANDOM_ITEMS  = 800;
    localparam int WATCHDOG_MAX  = 3000;

    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic [IRQ_W-1:0]  irq;
    } timer_result_t;

    typedef struct packed {
        req_t              req;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              typed;
        logic [DATA_W-1:0] rd;
        logic [IRQ_W-1:0]  irq;
    } directed_row_t;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [1:0]        req_type   = REQ_NONE;
    logic [ADDR_W-1:0] address    = '0;
    logic [DATA_W-1:0] write_data = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_lines;

    // Predicted timer state, one entry per channel.
    logic [DATA_W-1:0] load_val  [NUM_CHANNELS];
    logic [CTRL_W-1:0] ctrl_val  [NUM_CHANNELS];
    logic [DATA_W-1:0] count_val [NUM_CHANNELS];
    bit                run_val   [NUM_CHANNELS];
    int unsigned       presc_val [NUM_CHANNELS];
    bit                irq_val   [NUM_CHANNELS];

    timer_result_t pending_results [$];
    timer_result_t exp_res;

    int  errors      = 0;
    int  n_checked   = 0;
    int  n_reads     = 0;
    int  n_writes    = 0;
    int  n_ticks     = 0;
    int  n_expiries  = 0;
    int  idle_cycles = 0;
    int  stall_hold  = 0;
    bit  no_idle     = 1'b0;

    // Reads of reset state, bad channels and unknown offsets, ignored and taken writes,
    // readbacks and the first tick have fixed answers; the remaining rows are left to the predictor.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{REQ_READ,  8'h00, 32'h0000_0000, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'h04, 32'h0000_0000, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'h18, 32'h0000_0000, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'h20, 32'h0000_0000, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_NONE,  8'h00, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_WRITE, 8'h00, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'h00, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 2'b00},
        '{REQ_WRITE, 8'h04, 32'h1234_5678, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'h04, 32'h0000_0000, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_WRITE, 8'h0C, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'h0C, 32'h0000_0000, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_WRITE, 8'hF0, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_WRITE, 8'h00, 32'h0000_0002, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_WRITE, 8'h08, 32'hFFFF_FF23, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'h08, 32'h0000_0000, 1'b1, 32'h0000_0023, 2'b00},
        '{REQ_READ,  8'h04, 32'h0000_0000, 1'b1, 32'h0000_0002, 2'b00},
        '{REQ_TICK,  8'h00, 32'h0000_0000, 1'b1, 32'h0000_0000, 2'b00},
        '{REQ_TICK,  8'h00, 32'h0000_0000, 1'b0, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'h04, 32'h0000_0000, 1'b0, 32'h0000_0000, 2'b00},
        '{REQ_WRITE, 8'h10, 32'h0000_0000, 1'b0, 32'h0000_0000, 2'b00},
        '{REQ_WRITE, 8'h18, 32'h0000_0081, 1'b0, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'h14, 32'h0000_0000, 1'b0, 32'h0000_0000, 2'b00},
        '{REQ_TICK,  8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 2'b00},
        '{REQ_WRITE, 8'h18, 32'h0000_0000, 1'b0, 32'h0000_0000, 2'b00},
        '{REQ_READ,  8'hFF, 32'h0000_0000, 1'b0, 32'h0000_0000, 2'b00},
        '{REQ_WRITE, 8'h18, 32'h0000_00FF, 1'b0, 32'h0000_0000, 2'b00}
    };

    dual_countdown_timer_regs uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .address    (address),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .irq_lines  (irq_lines)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] reload_of(input int unsigned ch);
        return (load_val[ch] != '0) ? load_val[ch] : '1;
    endfunction

    function automatic void tick_channel(input int unsigned ch);
        if (!run_val[ch])
            return;
        if (ctrl_val[ch][CTRL_PRESCALE])
        begin
            presc_val[ch]++;
            if (presc_val[ch] < PRESCALE_DIVIDE)
                return;
            presc_val[ch] = 0;
        end
        if (count_val[ch] > 1)
        begin
            count_val[ch] = count_val[ch] - DATA_W'(1);
            return;
        end
        // The count has run out: the interrupt line, if enabled, latches until reset.
        n_expiries++;
        count_val[ch] = '0;
        if (ctrl_val[ch][CTRL_INT_EN])
            irq_val[ch] = 1'b1;
        if (ctrl_val[ch][CTRL_AUTO])
            count_val[ch] = reload_of(ch);
        else
            run_val[ch] = 1'b0;
    endfunction

    function automatic timer_result_t apply_request(input req_t req,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] data);
        timer_result_t res;
        int unsigned   ch;
        int unsigned   c;
        logic [3:0]    regsel;
        res    = '0;
        ch     = {28'd0, addr[7:4]};
        regsel = addr[3:0];
        if (req == REQ_TICK)
        begin
            for (c = 0; c < NUM_CHANNELS; c++)
                tick_channel(c);
        end
        else if (req == REQ_READ && ch < NUM_CHANNELS)
        begin
            case (regsel)
                REG_LOAD:  res.rd = load_val[ch];
                REG_VALUE: res.rd = count_val[ch];
                REG_CTRL:  res.rd = {{(DATA_W-CTRL_W){1'b0}}, ctrl_val[ch]};
                default:   res.rd = '0;
            endcase
        end
        else if (req == REQ_WRITE && ch < NUM_CHANNELS)
        begin
            if (regsel == REG_LOAD)
                load_val[ch] = data;
            else if (regsel == REG_CTRL)
            begin
                ctrl_val[ch]  = data[CTRL_W-1:0];
                presc_val[ch] = 0;
                run_val[ch]   = data[CTRL_ENABLE];
                if (data[CTRL_ENABLE])
                    count_val[ch] = reload_of(ch);
            end
        end
        for (c = 0; c < NUM_CHANNELS && c < IRQ_W; c++)
            res.irq[c] = irq_val[c];
        return res;
    endfunction

    // Mostly short idle spells, now and then a long one.
    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    task automatic send_item(input req_t req, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic typed,
                             input logic [DATA_W-1:0] trd, input logic [IRQ_W-1:0] tirq);
        int            gap;
        timer_result_t res;
        gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        address    <= addr;
        write_data <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = apply_request(req, addr, data);
        if (typed)
        begin
            res.rd  = trd;
            res.irq = tirq;
        end
        pending_results.push_back(res);
        case (req)
            REQ_READ:  n_reads++;
            REQ_WRITE: n_writes++;
            REQ_TICK:  n_ticks++;
            default:   ;
        endcase
    endtask

    // Random items are mostly ticks, plus register reads and timer programming with
    // mostly small reload values, so that channels expire often; the rest is noise.
    task automatic random_request(output req_t rq, output logic [ADDR_W-1:0] ad,
                                  output logic [DATA_W-1:0] wd);
        int         sel;
        int         pick;
        logic [3:0] chan;
        sel  = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        chan = 4'($urandom_range(0, NUM_CHANNELS - 1));
        ad   = ADDR_W'($urandom);
        wd   = $urandom;
        rq   = REQ_TICK;
        if (sel < 60 && sel >= 45)
        begin
            rq = REQ_READ;
            case ($urandom_range(0, 2))
                0:       ad = {chan, REG_LOAD};
                1:       ad = {chan, REG_VALUE};
                default: ad = {chan, REG_CTRL};
            endcase
        end
        else if (sel >= 60 && sel < 70)
        begin
            rq = REQ_WRITE;
            ad = {chan, REG_LOAD};
            if (pick < 6)
                wd = $urandom_range(1, 12);
            else if (pick < 8)
                wd = '0;
        end
        else if (sel >= 70 && sel < 82)
        begin
            rq = REQ_WRITE;
            ad = {chan, REG_CTRL};
            wd[CTRL_ENABLE]   = ($urandom_range(0, 4) != 0);
            wd[CTRL_PRESCALE] = ($urandom_range(0, 3) == 0);
        end
        else if (sel >= 82)
            rq = req_t'($urandom_range(0, 3));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || no_idle)
        begin
            out_stall  <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else if (!out_stall && $urandom_range(0, 2) == 0)
        begin
            out_stall  <= 1'b1;
            stall_hold <= idle_len();
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 25);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("Result with no item outstanding: read_data %h irq_lines %b",
                       read_data, irq_lines);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (read_data !== exp_res.rd)
                begin
                    $error("read_data: expected %h, got %h", exp_res.rd, read_data);
                    errors++;
                end
                if (irq_lines !== exp_res.irq)
                begin
                    $error("irq_lines: expected %b, got %b", exp_res.irq, irq_lines);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("Timeout after %0d cycles without any item moving", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                k;
        req_t              rq;
        logic [ADDR_W-1:0] ad;
        logic [DATA_W-1:0] wd;
        for (k = 0; k < NUM_CHANNELS; k++)
        begin
            load_val[k]  = '0;
            ctrl_val[k]  = '0;
            count_val[k] = '0;
            run_val[k]   = 1'b0;
            presc_val[k] = 0;
            irq_val[k]   = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < NUM_DIRECTED; k++)
            send_item(directed_rows[k].req, directed_rows[k].addr, directed_rows[k].data,
                      directed_rows[k].typed, directed_rows[k].rd, directed_rows[k].irq);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            // A stretch with back-to-back items and no output stalls.
            no_idle = (k >= 300 && k < 400);
            random_request(rq, ad, wd);
            send_item(rq, ad, wd, 1'b0, '0, '0);
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Checked %0d results: %0d reads, %0d writes, %0d ticks.",
                 n_checked, n_reads, n_writes, n_ticks);
        $display("Timers expired %0d times; final interrupt lines %b.", n_expiries, irq_lines);
        if (errors == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
